/* hw/rtl/hij_pkg.sv */
// ----------------------------------------------------------------------------
// hij_pkg
// shared constants and types for the hash index join block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hij_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DEF_BUCKETS  = 16;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_PROBE  = 2'd2;

    localparam int IN_W      = 64;   // key, payload
    localparam int IN_USER_W = 2;    // opcode
    localparam int OUT_W     = 96;   // row_key, outer_tag, inner_tag
    localparam int USER_W    = 2;    // matched, status

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_PRB_RD,
        ST_PRB_WALK,
        ST_PRB_EMIT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/hash_index_join.sv */
// ----------------------------------------------------------------------------
// hash_index_join
// equality join engine over a bucketed, chained multimap held in memories
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one word per command, the opcode in tuser: clear, insert
//   inner row, probe with an outer row. m_axis returns result words; tlast
//   marks the final result of a command, tuser carries matched and status.
//   the bucket is the low key bits, so the user must keep BUCKETS a power of two;
//   the block does not enforce it. clear and the spare opcode give no result;
//   the next word can be taken in the following cycle.
//   insert reads the bucket tail, then writes the entry and the link, then
//   hands the result to the output register; when the table is full the row
//   is dropped, the write is skipped and the status bit is set.
//   a probe reads the bucket head, then walks its chain through the entry
//   memories with a walk and an emit state per entry. a match is held back
//   until the next match or the end of the chain, so the final match can
//   carry tlast; an empty bucket goes straight to the unmatched word.
//   one command is handled at a time; the walk per entry is set by the
//   registered read of the entry memories.
//   reset empties all bucket heads (valid flops) and the entry count; the
//   other memories need no clearing as they are only read once written.
//   a stalled receiver holds the output register and pauses the walk at the
//   next match; the input is taken once the previous command has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hash_index_join
    import hij_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int BUCKETS  = DEF_BUCKETS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_W-1:0]      s_axis_tdata,   // key, payload
    input  wire logic [IN_USER_W-1:0] s_axis_tuser,   // opcode
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [OUT_W-1:0]          m_axis_tdata,   // row_key, outer_tag, inner_tag
    output logic [USER_W-1:0]         m_axis_tuser,   // matched, status
    output logic                      m_axis_tlast
);

    localparam int EW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // memories
    logic [31:0]  ekey_mem [CAPACITY];
    logic [31:0]  etag_mem [CAPACITY];
    logic [EW:0]  enext_mem[CAPACITY];
    logic [EW-1:0] head_mem[BUCKETS];
    logic [EW-1:0] tail_mem[BUCKETS];
    logic [BUCKETS-1:0] hvalid_reg;

    state_t state_reg, state_next;
    logic [31:0] key_reg, tag_reg;
    logic [BW-1:0] bkt_reg;
    logic [CW-1:0] cnt_reg;
    logic [EW-1:0] tail_q, cur_reg;
    logic [31:0] rkey_q, rtag_q;
    logic [EW:0] rnext_q;
    logic found_reg;
    logic [31:0] pend_tag_reg;

    logic        ov_reg;
    logic [31:0] o_key_reg, o_otag_reg, o_itag_reg;
    logic        o_match_reg, o_stat_reg, o_last_reg;

    logic accept, out_free, full;
    logic [1:0]  in_op;
    logic [31:0] in_key, in_tag;
    logic [BW-1:0] in_bkt;
    logic [EW-1:0] new_idx;
    logic hit, more;
    logic step_ok, emit_match, out_load;

    assign in_op  = s_axis_tuser;
    assign in_key = s_axis_tdata[31:0];
    assign in_tag = s_axis_tdata[63:32];
    assign in_bkt = (BUCKETS > 1) ? in_key[BW-1:0] : '0;
    assign out_free = !ov_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign full = (cnt_reg >= CW'(CAPACITY));
    assign new_idx = cnt_reg[EW-1:0];
    assign hit = (rkey_q == key_reg);
    assign more = rnext_q[EW];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (in_op == OP_INSERT)     state_next = ST_INS_RD;
                    else if (in_op == OP_PROBE) state_next = ST_PRB_RD;
                end
            ST_INS_RD:  state_next = full ? ST_OUT : ST_INS_WR;
            ST_INS_WR:  state_next = ST_OUT;
            ST_PRB_RD:  state_next = hvalid_reg[bkt_reg] ? ST_PRB_WALK : ST_OUT;
            ST_PRB_WALK: state_next = ST_PRB_EMIT;
            ST_PRB_EMIT:
                if (step_ok)
                    state_next = more ? ST_PRB_WALK : ST_OUT;
            ST_OUT:
                if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // controls: a held match goes out when the next one is found
    always_comb
    begin
        s_axis_tready = 1'b0;
        step_ok       = 1'b0;
        emit_match    = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                s_axis_tready = !ov_reg;
            ST_PRB_EMIT:
            begin
                step_ok    = !(hit && found_reg) || out_free;
                emit_match = hit && found_reg && out_free;
            end
            ST_OUT:
                out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hvalid_reg <= '0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= (ov_reg && !m_axis_tready) || emit_match || out_load;
            if (accept && in_op == OP_CLEAR)
            begin
                hvalid_reg <= '0;
                cnt_reg    <= '0;
            end
            if (accept)
                found_reg <= 1'b0;
            else if (state_reg == ST_PRB_EMIT && hit && step_ok)
                found_reg <= 1'b1;
            if (state_reg == ST_INS_WR)
            begin
                hvalid_reg[bkt_reg] <= 1'b1;
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // memories, chain walk and the output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= in_key;
            tag_reg <= in_tag;
            bkt_reg <= in_bkt;
        end
        tail_q <= tail_mem[bkt_reg];
        if (state_reg == ST_INS_RD && !full)
            enext_mem[new_idx] <= '0;
        if (state_reg == ST_INS_WR)
        begin
            ekey_mem[new_idx]  <= key_reg;
            etag_mem[new_idx]  <= tag_reg;
            if (!hvalid_reg[bkt_reg]) head_mem[bkt_reg] <= new_idx;
            else enext_mem[tail_q] <= {1'b1, new_idx};
            tail_mem[bkt_reg] <= new_idx;
        end
        if (state_reg == ST_PRB_RD) cur_reg <= head_mem[bkt_reg];
        if (state_reg == ST_PRB_EMIT && more && step_ok)
            cur_reg <= rnext_q[EW-1:0];
        rkey_q  <= ekey_mem[cur_reg];
        rtag_q  <= etag_mem[cur_reg];
        rnext_q <= enext_mem[cur_reg];
        if (state_reg == ST_PRB_EMIT && hit && step_ok)
            pend_tag_reg <= rtag_q;
        // held match: mid-chain word, or the closing word at chain end
        if (emit_match || (out_load && found_reg))
        begin
            o_key_reg <= key_reg; o_otag_reg <= tag_reg; o_itag_reg <= pend_tag_reg;
            o_match_reg <= 1'b1; o_stat_reg <= 1'b0; o_last_reg <= out_load;
        end
        if (state_reg == ST_INS_RD)
        begin
            o_key_reg <= key_reg; o_otag_reg <= '0; o_itag_reg <= tag_reg;
            o_match_reg <= 1'b0; o_stat_reg <= full; o_last_reg <= 1'b1;
        end
        if (state_reg == ST_PRB_RD)
        begin
            o_key_reg <= key_reg; o_otag_reg <= tag_reg; o_itag_reg <= '0;
            o_match_reg <= 1'b0; o_stat_reg <= 1'b0; o_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {o_itag_reg, o_otag_reg, o_key_reg};
    assign m_axis_tuser  = {o_stat_reg, o_match_reg};
    assign m_axis_tlast  = o_last_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY)) else $error("entry count overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_axis_tready |=> ov_reg && $stable(m_axis_tdata))
        else $error("output changed under stall");

endmodule

`default_nettype wire
